@@ rtl/paof_pkg.sv @@
`timescale 1ns / 1ps

package paof_pkg;

  localparam int TIME_W     = 32;
  localparam int DIST_W     = 16;
  localparam int LEN_W      = 16;
  localparam int LVL_W      = 8;
  localparam int CFG_W      = 32;
  localparam int IDX_W      = 2;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;
  localparam int FUNC_W     = 2;
  localparam int PROD_W     = LVL_W + LEN_W;
  localparam int DIV_STEPS  = LVL_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [FUNC_W-1:0] FN_TICK     = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ACTIVITY = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DISTANCE = 2'd2;

  localparam logic [IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd0;
  localparam logic [IDX_W-1:0] REG_FADE_LENGTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_NEAR_LIMIT   = 2'd2;
  localparam logic [IDX_W-1:0] REG_FAR_LIMIT    = 2'd3;

  localparam logic [TIME_W-1:0] RST_IDLE_TIMEOUT = 32'd30000;
  localparam logic [LEN_W-1:0]  RST_FADE_LENGTH  = 16'd2000;
  localparam logic [DIST_W-1:0] RST_NEAR_LIMIT   = 16'd100;
  localparam logic [DIST_W-1:0] RST_FAR_LIMIT    = 16'd300;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACTIVE = 2'd1,
    PH_FADING = 2'd2,
    PH_OFF    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CL_UNKNOWN = 2'd0,
    CL_NEAR    = 2'd1,
    CL_FAR     = 2'd2
  } dclass_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic mul;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/paof_ctrl.sv @@
`timescale 1ns / 1ps

module paof_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  paof_pkg::stat_t stat,
  output paof_pkg::cmd_t  cmd
);

  paof_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= paof_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      paof_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = paof_pkg::ST_EVAL;
      end
      paof_pkg::ST_EVAL: begin
        state_next = stat.need_div ? paof_pkg::ST_MUL : paof_pkg::ST_OUT;
      end
      paof_pkg::ST_MUL: begin
        state_next = paof_pkg::ST_DIV;
      end
      paof_pkg::ST_DIV: begin
        if (stat.div_done) state_next = paof_pkg::ST_OUT;
      end
      paof_pkg::ST_OUT: begin
        if (stat.out_free) state_next = paof_pkg::ST_IDLE;
      end
      default: state_next = paof_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      paof_pkg::ST_IDLE: begin
        s_tready    = !rst;
        cmd.load_in = s_tvalid && !rst;
      end
      paof_pkg::ST_EVAL: cmd.eval     = 1'b1;
      paof_pkg::ST_MUL:  cmd.mul      = 1'b1;
      paof_pkg::ST_DIV:  cmd.div_step = 1'b1;
      paof_pkg::ST_OUT:  cmd.load_out = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/paof_dp.sv @@
`timescale 1ns / 1ps

module paof_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  paof_pkg::cmd_t                   cmd,
  output paof_pkg::stat_t                  stat,
  input  logic [paof_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [paof_pkg::FUNC_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [paof_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             cfg_we,
  input  logic [paof_pkg::IDX_W-1:0]       cfg_index,
  input  logic [paof_pkg::CFG_W-1:0]       cfg_data
);

  // config
  logic [paof_pkg::TIME_W-1:0] idle_timeout;
  logic [paof_pkg::LEN_W-1:0]  fade_length;
  logic [paof_pkg::DIST_W-1:0] near_limit;
  logic [paof_pkg::DIST_W-1:0] far_limit;

  // latched input word
  logic [paof_pkg::FUNC_W-1:0] in_func;
  logic [paof_pkg::TIME_W-1:0] in_now;
  logic [paof_pkg::DIST_W-1:0] in_dist;
  logic [paof_pkg::LVL_W-1:0]  in_shown;

  // block state
  paof_pkg::phase_t            phase_reg;
  paof_pkg::dclass_t           class_reg;
  logic [paof_pkg::TIME_W-1:0] activity_stamp;
  logic [paof_pkg::TIME_W-1:0] fade_start_stamp;
  logic [paof_pkg::LVL_W-1:0]  fade_base_level;

  // step results and divider
  logic                        calc_flag;
  logic                        clr_flag;
  logic [paof_pkg::LEN_W-1:0]  fade_span;
  logic [paof_pkg::LEN_W-1:0]  rem;
  logic [paof_pkg::LVL_W-1:0]  quot;
  logic [paof_pkg::CNT_W-1:0]  cnt;
  logic                        out_valid;
  logic [paof_pkg::OUT_DATA_W-1:0] out_data;

  logic [paof_pkg::TIME_W-1:0] idle_time;
  logic [paof_pkg::TIME_W-1:0] elapsed;
  logic                        timed_out;
  logic                        fade_over;
  logic                        is_tick;
  logic                        fade_tick;
  paof_pkg::dclass_t           class_new;
  logic [paof_pkg::PROD_W-1:0] product;
  logic [paof_pkg::LEN_W:0]    trial;
  logic [paof_pkg::LEN_W:0]    trial_diff;
  logic                        fits;
  logic                        wr;
  logic [paof_pkg::LVL_W-1:0]  level;

  assign idle_time = in_now - activity_stamp;
  assign elapsed   = in_now - fade_start_stamp;
  assign timed_out = idle_time >= idle_timeout;
  assign fade_over = elapsed >= paof_pkg::TIME_W'(fade_length);
  assign is_tick   = in_func == paof_pkg::FN_TICK;
  assign fade_tick = is_tick && (phase_reg == paof_pkg::PH_FADING);

  always_comb begin
    class_new = class_reg;
    if (in_dist < near_limit) begin
      class_new = paof_pkg::CL_NEAR;
    end else if (in_dist > far_limit) begin
      class_new = paof_pkg::CL_FAR;
    end
  end

  assign product    = paof_pkg::PROD_W'(fade_base_level) * paof_pkg::PROD_W'(fade_span);
  assign trial      = {rem, quot[paof_pkg::LVL_W-1]};
  assign fits       = trial >= {1'b0, fade_length};
  assign trial_diff = trial - {1'b0, fade_length};

  assign stat.need_div = fade_tick && !fade_over;
  assign stat.div_done = cnt == paof_pkg::CNT_W'(paof_pkg::DIV_STEPS - 1);
  assign stat.out_free = !out_valid || m_tready;

  assign wr    = calc_flag && (quot != in_shown);
  assign level = wr ? quot : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= paof_pkg::RST_IDLE_TIMEOUT;
      fade_length  <= paof_pkg::RST_FADE_LENGTH;
      near_limit   <= paof_pkg::RST_NEAR_LIMIT;
      far_limit    <= paof_pkg::RST_FAR_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        paof_pkg::REG_IDLE_TIMEOUT: idle_timeout <= cfg_data[paof_pkg::TIME_W-1:0];
        paof_pkg::REG_FADE_LENGTH:  fade_length  <= cfg_data[paof_pkg::LEN_W-1:0];
        paof_pkg::REG_NEAR_LIMIT:   near_limit   <= cfg_data[paof_pkg::DIST_W-1:0];
        paof_pkg::REG_FAR_LIMIT:    far_limit    <= cfg_data[paof_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_func  <= s_tuser;
      in_now   <= s_tdata[paof_pkg::TIME_W-1:0];
      in_dist  <= s_tdata[paof_pkg::TIME_W +: paof_pkg::DIST_W];
      in_shown <= s_tdata[paof_pkg::TIME_W + paof_pkg::DIST_W +: paof_pkg::LVL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg        <= paof_pkg::PH_IDLE;
      class_reg        <= paof_pkg::CL_UNKNOWN;
      activity_stamp   <= '0;
      fade_start_stamp <= '0;
      fade_base_level  <= '0;
      calc_flag        <= 1'b0;
      clr_flag         <= 1'b0;
    end else if (cmd.eval) begin
      calc_flag <= fade_tick && !fade_over;
      clr_flag  <= fade_tick && fade_over;
      if (is_tick) begin
        if (phase_reg == paof_pkg::PH_ACTIVE && timed_out) begin
          phase_reg        <= paof_pkg::PH_FADING;
          fade_start_stamp <= in_now;
          fade_base_level  <= in_shown;
        end else if (fade_tick && fade_over) begin
          phase_reg <= paof_pkg::PH_OFF;
        end
      end else if (in_func == paof_pkg::FN_ACTIVITY) begin
        activity_stamp <= in_now;
        phase_reg      <= paof_pkg::PH_ACTIVE;
      end else if (in_func == paof_pkg::FN_DISTANCE) begin
        if (class_new != class_reg) begin
          class_reg <= class_new;
          if (class_new == paof_pkg::CL_NEAR) begin
            activity_stamp <= in_now;
            phase_reg      <= paof_pkg::PH_ACTIVE;
          end
        end
      end
    end
  end

  // base * (L - e) / L; quotient < 2^LVL_W, so the top bits already sit below L
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      fade_span <= fade_length - elapsed[paof_pkg::LEN_W-1:0];
    end
    if (cmd.mul) begin
      rem  <= product[paof_pkg::PROD_W-1:paof_pkg::LVL_W];
      quot <= product[paof_pkg::LVL_W-1:0];
      cnt  <= '0;
    end else if (cmd.div_step) begin
      rem  <= fits ? trial_diff[paof_pkg::LEN_W-1:0] : trial[paof_pkg::LEN_W-1:0];
      quot <= {quot[paof_pkg::LVL_W-2:0], fits};
      cnt  <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {2'b00, class_reg, phase_reg, clr_flag, level, wr};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

@@ rtl/presence_auto_off_fader.sv @@
`timescale 1ns / 1ps
// Each accepted word passes through the EVAL and OUT states; a fading tick that
// computes a new level also passes through the MUL state and 8 divide steps.
// No new word is accepted until its result enters the output register, which waits
// on m_tready; the restoring divider retires one quotient bit per cycle.
// Reset: synchronous rst clears phase, class, stamps and output valid and
// loads the registers with their defaults.

module presence_auto_off_fader (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // now_ms[31:0], range_cm[47:32], shown_brightness[55:48]
  input  logic [paof_pkg::IN_DATA_W-1:0]   s_tdata,
  // func[1:0]
  input  logic [paof_pkg::FUNC_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // write_brightness[0], brightness_out[8:1], clear_leds[9], off_phase[11:10],
  // distance_class[13:12], zero[15:14]
  output logic [paof_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             cfg_we,
  input  logic [paof_pkg::IDX_W-1:0]       cfg_index,
  input  logic [paof_pkg::CFG_W-1:0]       cfg_data
);

  paof_pkg::cmd_t  cmd;
  paof_pkg::stat_t stat;

  paof_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  paof_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import paof_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_WORDS  = 240;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_PHASE   = 4;
  localparam int MAX_REPORTS  = 10;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic              wr;
    logic [LVL_W-1:0]  level;
    logic              clr;
    phase_t            phase;
    dclass_t           dclass;
  } lamp_result_t;

  // sel is func on a word row, register index on a write row; val is now_ms or the value
  typedef struct packed {
    logic              is_cfg;
    logic [1:0]        sel;
    logic [31:0]       val;
    logic [DIST_W-1:0] range_cm;
    logic [LVL_W-1:0]  shown;
    logic              typed;
    lamp_result_t      res;
  } plan_row_t;

  typedef struct packed {
    logic [TIME_W-1:0] timeout;
    logic [LEN_W-1:0]  fade;
    logic [DIST_W-1:0] near;
    logic [DIST_W-1:0] far;
    int                send_pct;
    int                recv_pct;
  } setting_t;

  localparam lamp_result_t NO_RESULT = '{1'b0, 8'd0, 1'b0, PH_IDLE, CL_UNKNOWN};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [FUNC_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // predictor copy of registers and state
  logic [TIME_W-1:0] cfg_timeout = RST_IDLE_TIMEOUT;
  logic [LEN_W-1:0]  cfg_fade    = RST_FADE_LENGTH;
  logic [DIST_W-1:0] cfg_near    = RST_NEAR_LIMIT;
  logic [DIST_W-1:0] cfg_far     = RST_FAR_LIMIT;
  phase_t            lamp_phase  = PH_IDLE;
  dclass_t           lamp_class  = CL_UNKNOWN;
  logic [TIME_W-1:0] activity_at = '0;
  logic [TIME_W-1:0] fade_from   = '0;
  logic [LVL_W-1:0]  fade_base   = '0;

  lamp_result_t      lamp_updates_q[$];

  logic [TIME_W-1:0] clock_ms = '0;
  logic [LVL_W-1:0]  lamp_level = '0;
  int mismatches = 0;
  int words_sent = 0;
  int level_writes = 0;
  int led_clears = 0;
  int cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  presence_auto_off_fader i_dut (.*);

  always #HALF_PERIOD clk = ~clk;

  function automatic lamp_result_t predict_lamp(input logic [FUNC_W-1:0] fn,
      input logic [TIME_W-1:0] now, input logic [DIST_W-1:0] range_cm,
      input logic [LVL_W-1:0] shown);
    lamp_result_t res;
    logic [TIME_W-1:0] span;
    logic [PROD_W-1:0] scaled;
    dclass_t nc;
    res = NO_RESULT;
    case (fn)
      FN_TICK: begin
        if (lamp_phase == PH_ACTIVE) begin
          span = now - activity_at;
          if (span >= cfg_timeout) begin
            lamp_phase = PH_FADING;
            fade_from = now;
            fade_base = shown;
          end
        end else if (lamp_phase == PH_FADING) begin
          span = now - fade_from;
          if (span >= TIME_W'(cfg_fade)) begin
            res.clr = 1'b1;
            lamp_phase = PH_OFF;
          end else begin
            scaled = (PROD_W'(fade_base) * PROD_W'(cfg_fade - span[LEN_W-1:0]))
                     / PROD_W'(cfg_fade);
            if (scaled[LVL_W-1:0] != shown) begin
              res.wr = 1'b1;
              res.level = scaled[LVL_W-1:0];
            end
          end
        end
      end
      FN_ACTIVITY: begin
        activity_at = now;
        lamp_phase = PH_ACTIVE;
      end
      FN_DISTANCE: begin
        nc = lamp_class;
        if (range_cm < cfg_near) nc = CL_NEAR;
        else if (range_cm > cfg_far) nc = CL_FAR;
        if (nc != lamp_class) begin
          lamp_class = nc;
          if (nc == CL_NEAR) begin
            activity_at = now;
            lamp_phase = PH_ACTIVE;
          end
        end
      end
      default: ;
    endcase
    res.phase = lamp_phase;
    res.dclass = lamp_class;
    return res;
  endfunction

  task automatic offer_word(input logic [FUNC_W-1:0] fn, input logic [TIME_W-1:0] now,
      input logic [DIST_W-1:0] range_cm, input logic [LVL_W-1:0] shown,
      input logic typed, input lamp_result_t typed_res);
    lamp_result_t pred;
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {shown, range_cm, now};
    s_tuser = fn;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = predict_lamp(fn, now, range_cm, shown);
    lamp_updates_q.push_back(typed ? typed_res : pred);
    words_sent++;
    if (pred.wr) begin
      level_writes++;
      lamp_level = pred.level;
    end
    if (pred.clr) begin
      led_clears++;
      lamp_level = '0;
    end
    if (fn == FN_ACTIVITY) lamp_level = LVL_W'($urandom);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    while (lamp_updates_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_IDLE_TIMEOUT: cfg_timeout = value;
      REG_FADE_LENGTH:  cfg_fade = value[LEN_W-1:0];
      REG_NEAR_LIMIT:   cfg_near = value[DIST_W-1:0];
      default:          cfg_far = value[DIST_W-1:0];
    endcase
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready = 1'b0;
    end else begin
      m_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    lamp_result_t got;
    lamp_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[0], m_tdata[8:1], m_tdata[9], phase_t'(m_tdata[11:10]),
              dclass_t'(m_tdata[13:12])};
      if (lamp_updates_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected word %h", m_tdata);
      end else begin
        want = lamp_updates_q.pop_front();
        if (got.wr != want.wr || got.level != want.level || got.clr != want.clr ||
            got.phase != want.phase || got.dclass != want.dclass) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: exp wr=%0b lvl=%0d clr=%0b ph=%0d cl=%0d,",
                      " got wr=%0b lvl=%0d clr=%0b ph=%0d cl=%0d"},
                     want.wr, want.level, want.clr, want.phase, want.dclass,
                     got.wr, got.level, got.clr, got.phase, got.dclass);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [25];
    setting_t phases [6];
    setting_t cur;
    logic [FUNC_W-1:0] fn;
    logic [DIST_W-1:0] range_cm;
    logic [LVL_W-1:0] shown;
    int unsigned pick;

    plan = '{
      '{1'b0, FN_TICK,     32'd0,          16'd0,     8'd0,   1'b1,
        '{1'b0, 8'd0, 1'b0, PH_IDLE, CL_UNKNOWN}},
      '{1'b0, FN_UNUSED,   32'hFFFFFFFF,   16'hFFFF,  8'hFF,  1'b1,
        '{1'b0, 8'd0, 1'b0, PH_IDLE, CL_UNKNOWN}},
      '{1'b0, FN_DISTANCE, 32'd10,         16'd200,   8'd0,   1'b1,
        '{1'b0, 8'd0, 1'b0, PH_IDLE, CL_UNKNOWN}},
      '{1'b0, FN_DISTANCE, 32'd100,        16'd99,    8'd0,   1'b1,
        '{1'b0, 8'd0, 1'b0, PH_ACTIVE, CL_NEAR}},
      '{1'b0, FN_DISTANCE, 32'd200,        16'd0,     8'd0,   1'b1,
        '{1'b0, 8'd0, 1'b0, PH_ACTIVE, CL_NEAR}},
      '{1'b0, FN_TICK,     32'd30100,      16'd0,     8'd200, 1'b1,
        '{1'b0, 8'd0, 1'b0, PH_FADING, CL_NEAR}},
      '{1'b0, FN_TICK,     32'd31100,      16'd0,     8'd200, 1'b1,
        '{1'b1, 8'd100, 1'b0, PH_FADING, CL_NEAR}},
      '{1'b0, FN_TICK,     32'd31100,      16'd0,     8'd100, 1'b1,
        '{1'b0, 8'd0, 1'b0, PH_FADING, CL_NEAR}},
      '{1'b0, FN_TICK,     32'd32099,      16'd0,     8'd100, 1'b1,
        '{1'b1, 8'd0, 1'b0, PH_FADING, CL_NEAR}},
      '{1'b0, FN_DISTANCE, 32'd32099,      16'hFFFF,  8'd0,   1'b1,
        '{1'b0, 8'd0, 1'b0, PH_FADING, CL_FAR}},
      '{1'b0, FN_DISTANCE, 32'd32099,      16'd300,   8'd0,   1'b1,
        '{1'b0, 8'd0, 1'b0, PH_FADING, CL_FAR}},
      '{1'b0, FN_DISTANCE, 32'd32099,      16'd100,   8'd0,   1'b1,
        '{1'b0, 8'd0, 1'b0, PH_FADING, CL_FAR}},
      '{1'b0, FN_TICK,     32'd32100,      16'd0,     8'd0,   1'b1,
        '{1'b0, 8'd0, 1'b1, PH_OFF, CL_FAR}},
      '{1'b0, FN_TICK,     32'd40000,      16'd0,     8'd0,   1'b1,
        '{1'b0, 8'd0, 1'b0, PH_OFF, CL_FAR}},
      '{1'b0, FN_ACTIVITY, 32'hFFFFFFF0,   16'd0,     8'd0,   1'b1,
        '{1'b0, 8'd0, 1'b0, PH_ACTIVE, CL_FAR}},
      '{1'b0, FN_TICK,     32'h00007520,   16'd0,     8'hFF,  1'b1,
        '{1'b0, 8'd0, 1'b0, PH_FADING, CL_FAR}},
      '{1'b0, FN_TICK,     32'h00007521,   16'd0,     8'hFF,  1'b0, NO_RESULT},
      '{1'b1, REG_FADE_LENGTH,  32'd0,     16'd0,     8'd0,   1'b0, NO_RESULT},
      '{1'b0, FN_TICK,     32'h00007522,   16'd0,     8'hFE,  1'b1,
        '{1'b0, 8'd0, 1'b1, PH_OFF, CL_FAR}},
      '{1'b1, REG_NEAR_LIMIT,   32'd500,   16'd0,     8'd0,   1'b0, NO_RESULT},
      '{1'b1, REG_FAR_LIMIT,    32'd200,   16'd0,     8'd0,   1'b0, NO_RESULT},
      '{1'b0, FN_DISTANCE, 32'd5,          16'd300,   8'd0,   1'b1,
        '{1'b0, 8'd0, 1'b0, PH_ACTIVE, CL_NEAR}},
      '{1'b0, FN_DISTANCE, 32'd6,          16'd600,   8'd0,   1'b1,
        '{1'b0, 8'd0, 1'b0, PH_ACTIVE, CL_FAR}},
      '{1'b0, FN_ACTIVITY, 32'd0,          16'd0,     8'd0,   1'b0, NO_RESULT},
      '{1'b0, FN_TICK,     32'd0,          16'd0,     8'h5A,  1'b0, NO_RESULT}
    };

    phases = '{
      '{32'd20,       16'd200,   16'd100,   16'd300,   0,  0},
      '{32'd0,        16'd1,     16'd0,     16'd0,     49, 0},
      '{32'hFFFFFFFF, 16'hFFFF,  16'hFFFF,  16'hFFFF,  0,  49},
      '{32'd7,        16'd0,     16'd500,   16'd200,   8,  8},
      '{32'd0,        16'd1,     16'd0,     16'd0,     0,  0},
      '{32'd40,       16'd255,   16'd120,   16'd260,   0,  49}
    };
    phases[HOLD_PHASE].timeout = $urandom_range(64);
    phases[HOLD_PHASE].fade = LEN_W'($urandom_range(600, 1));
    phases[HOLD_PHASE].near = DIST_W'($urandom_range(1000));
    phases[HOLD_PHASE].far = DIST_W'($urandom_range(1000));

    repeat (4) @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].sel, plan[i].val);
      else offer_word(plan[i].sel, plan[i].val, plan[i].range_cm, plan[i].shown,
                      plan[i].typed, plan[i].res);
    end

    foreach (phases[p]) begin
      cur = phases[p];
      write_reg(REG_IDLE_TIMEOUT, cur.timeout);
      write_reg(REG_FADE_LENGTH, CFG_W'(cur.fade));
      write_reg(REG_NEAR_LIMIT, CFG_W'(cur.near));
      write_reg(REG_FAR_LIMIT, CFG_W'(cur.far));
      send_gap_pct = cur.send_pct;
      recv_stall_pct = cur.recv_pct;
      clock_ms = $urandom;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == HOLD_PHASE && n == PHASE_WORDS / 2) hold_req++;
        pick = $urandom_range(99);
        if (pick < 55) fn = FN_TICK;
        else if (pick < 68) fn = FN_ACTIVITY;
        else if (pick < 95) fn = FN_DISTANCE;
        else fn = FN_UNUSED;
        // time moves in steps of up to fade/6 + 2, jumps by the timeout plus 0..3, or jumps at random
        pick = $urandom_range(99);
        if (pick < 12) clock_ms += cfg_timeout + $urandom_range(3);
        else if (pick < 16) clock_ms = $urandom;
        else if (pick >= 30) clock_ms += $urandom_range(cfg_fade / 6 + 2, 1);
        pick = $urandom_range(99);
        if (pick < 30) range_cm = cfg_near + DIST_W'($urandom_range(4)) - 16'd2;
        else if (pick < 60) range_cm = cfg_far + DIST_W'($urandom_range(4)) - 16'd2;
        else if (pick < 80) range_cm = DIST_W'($urandom);
        else if (pick < 90) range_cm = '0;
        else range_cm = '1;
        pick = $urandom_range(99);
        if (pick < 60) shown = lamp_level;
        else if (pick < 80) shown = LVL_W'($urandom);
        else if (pick < 90) shown = '0;
        else shown = '1;
        offer_word(fn, clock_ms, range_cm, shown, 1'b0, NO_RESULT);
      end
    end

    while (lamp_updates_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words over %0d register settings under mixed stalls and one hold-off",
             words_sent, $size(phases) + 2);
    $display("Fade level writes: %0d, LED clears: %0d, mismatches: %0d",
             level_writes, led_clears, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
